FILE: design/lock_table_with_revoke_retry_core_defines.svh
// Assertion macros used by the checker file.
`ifndef LOCK_TABLE_WITH_REVOKE_RETRY_CORE_DEFINES_SVH
`define LOCK_TABLE_WITH_REVOKE_RETRY_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LTR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LTR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/ltr_pkg.sv
package ltr_pkg;

  localparam int NUM_LOCKS   = 256;
  localparam int NUM_CLIENTS = 16;
  localparam int LOCK_AW     = $clog2(NUM_LOCKS);
  localparam int CL_AW       = $clog2(NUM_CLIENTS);
  localparam int CNT_W       = $clog2(NUM_CLIENTS + 1);
  localparam int WAIT_AW     = LOCK_AW + CL_AW;
  localparam int SEQ_W       = 32;

  localparam logic [1:0] KIND_REPLY  = 2'd0;
  localparam logic [1:0] KIND_REVOKE = 2'd1;
  localparam logic [1:0] KIND_RETRY  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RETRY = 2'd1;
  localparam logic [1:0] ST_ERR   = 2'd2;

  localparam logic REQ_ACQUIRE = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  typedef struct packed {
    logic             held;
    logic             rdone;
    logic [CNT_W-1:0] cnt;
    logic [3:0]       hclient;
    logic [SEQ_W-1:0] hseq;
  } lock_ent_t;

  typedef struct packed {
    logic [3:0]       client;
    logic [SEQ_W-1:0] seq;
  } waiter_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       status;
    logic [3:0]       client;
    logic [SEQ_W-1:0] seq;
  } res_t;

endpackage

FILE: design/ltr_lock_mem.sv
module ltr_lock_mem
  import ltr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rd_en,
  input  logic [LOCK_AW-1:0] rd_addr,
  output lock_ent_t          rd_data,
  input  logic               wr_en,
  input  logic [LOCK_AW-1:0] wr_addr,
  input  lock_ent_t          wr_data
);

  lock_ent_t              mem [NUM_LOCKS];
  logic [NUM_LOCKS-1:0]   vld_r;
  lock_ent_t              dat_r;
  logic                   dvld_r;

  // An entry never written reads as a free lock with an empty waiter list.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      dat_r  <= mem[rd_addr];
      dvld_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = dvld_r ? dat_r : '0;

endmodule

FILE: design/ltr_wait_mem.sv
module ltr_wait_mem
  import ltr_pkg::*;
(
  input  logic               clk,
  input  logic               rd_en,
  input  logic [WAIT_AW-1:0] rd_addr,
  output waiter_t            rd_data,
  input  logic               wr_en,
  input  logic [WAIT_AW-1:0] wr_addr,
  input  waiter_t            wr_data
);

  waiter_t mem [NUM_LOCKS * NUM_CLIENTS];
  waiter_t dat_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      dat_r <= mem[rd_addr];
    end
  end

  assign rd_data = dat_r;

endmodule

FILE: design/lock_table_with_revoke_retry_core.sv
// Lock table with revoke and retry messages.
// Input channel in_*: one request per transaction, in_tuser is the request type
// (acquire or release), in_tdata carries lock, client and sequence number.
// Output channel out_*: one or two result transactions per request; the reply
// to the requester comes first, a revoke or retry message may follow, and
// out_tlast marks the final one. out_tuser gives the message kind.
// cfg_wr_en/cfg_wr_data write the primary flag; write it only while idle.
// One request is handled at a time. After it is accepted the lock entry is read
// in S_LOOK, waiter entries are read in S_SCAN and the results are built in
// S_FIN, then offered from S_OUT0. The number of waiter entries read is the lock's waiter
// count (at most 16) for an acquire and at most one for a release. The list is
// read one entry per cycle from a memory with one read and one write port, and
// compacted or updated in place.
// The next request is taken in the cycle after the last result is accepted.
// If the receiver stalls, the result is held on out_tdata until taken.
// Reset empties every waiter list, frees every lock and sets the primary
// flag; it takes effect at once, with no clearing pass.
module lock_table_with_revoke_retry_core
  import ltr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // lock_id[7:0], client_id[11:8], seq_num[43:12], zero
  input  logic [0:0]  in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // status[1:0], lock_out[9:2], client_out[13:10],
                                  // seq_out[45:14], zero
  output logic [1:0]  out_tuser,  // msg_kind
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_wr_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_OUT0 = 3'd4;
  localparam logic [2:0] S_OUT1 = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic              prim_r;
  logic              rel_r;
  logic [7:0]        lk_r;
  logic [3:0]        cl_r;
  logic [SEQ_W-1:0]  sq_r;
  lock_ent_t         ent_r;
  logic [CNT_W-1:0]  len_r;
  logic [CNT_W-1:0]  rdi_r, rdi_nxt;
  logic [CNT_W-1:0]  w_r, w_nxt;
  logic              pv_r;
  logic [CL_AW-1:0]  pi_r;
  logic              found_r, found_nxt;
  waiter_t           fw_r, fw_nxt;
  res_t              r0_r, r1_r, r0_nxt, r1_nxt;
  logic              two_r, two_nxt;

  lock_ent_t         lrd, lwr;
  logic              lwe;
  waiter_t           wrd, wwr;
  logic              wwe, wre;
  logic [WAIT_AW-1:0] wwa, wra;
  logic              issue;
  logic [LOCK_AW-1:0] lidx;
  logic              in_acc;
  logic              rel_ok;
  logic              can_add;

  assign lidx   = lk_r[LOCK_AW-1:0];
  assign in_acc = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign issue  = (state_r == S_SCAN) && (rdi_r < len_r);
  assign wre    = issue;
  assign wra    = {lidx, rdi_r[CL_AW-1:0]};

  ltr_lock_mem u_lock (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (in_tdata[LOCK_AW-1:0]),
    .rd_data (lrd),
    .wr_en   (lwe),
    .wr_addr (lidx),
    .wr_data (lwr)
  );

  ltr_wait_mem u_wait (
    .clk     (clk),
    .rd_en   (wre),
    .rd_addr (wra),
    .rd_data (wrd),
    .wr_en   (wwe),
    .wr_addr (wwa),
    .wr_data (wwr)
  );

  assign rel_ok  = ent_r.held && (ent_r.hclient == cl_r) && (ent_r.hseq == sq_r);
  assign can_add = !found_r && (ent_r.cnt < CNT_W'(NUM_CLIENTS));

  always_comb begin
    state_nxt = state_r;
    rdi_nxt   = rdi_r;
    w_nxt     = w_r;
    found_nxt = found_r;
    fw_nxt    = fw_r;
    r0_nxt    = r0_r;
    r1_nxt    = r1_r;
    two_nxt   = two_r;
    wwe       = 1'b0;
    wwa       = {lidx, pi_r};
    wwr       = wrd;
    lwe       = 1'b0;
    lwr       = ent_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        rdi_nxt   = '0;
        w_nxt     = '0;
        found_nxt = 1'b0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        rdi_nxt = rdi_r + CNT_W'(issue);
        if (pv_r) begin
          if (rel_r == REQ_RELEASE) begin
            fw_nxt = wrd;
          end else if (!ent_r.held) begin
            // Compact the list, dropping the new holder.
            if (wrd.client != cl_r) begin
              wwe   = 1'b1;
              wwa   = {lidx, w_r[CL_AW-1:0]};
              w_nxt = w_r + CNT_W'(1);
            end
          end else if (wrd.client == cl_r && !found_r) begin
            wwe       = 1'b1;
            wwr.seq   = sq_r;
            found_nxt = 1'b1;
          end
        end
        if (!issue && !pv_r) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        lwe     = 1'b1;
        two_nxt = 1'b0;
        r0_nxt  = '{kind: KIND_REPLY, status: ST_OK, client: cl_r, seq: sq_r};
        r1_nxt  = '{kind: KIND_REVOKE, status: ST_OK, client: ent_r.hclient,
                    seq: ent_r.hseq};
        if (rel_r == REQ_ACQUIRE) begin
          if (!ent_r.held) begin
            lwr.held    = 1'b1;
            lwr.cnt     = w_r;
            lwr.hclient = cl_r;
            lwr.hseq    = sq_r;
          end else begin
            r0_nxt.status = ST_RETRY;
            if (can_add) begin
              wwe        = 1'b1;
              wwa        = {lidx, ent_r.cnt[CL_AW-1:0]};
              wwr.client = cl_r;
              wwr.seq    = sq_r;
              lwr.cnt    = ent_r.cnt + CNT_W'(1);
            end
            if (!ent_r.rdone) begin
              lwr.rdone = 1'b1;
              two_nxt   = prim_r;
            end
          end
        end else if (rel_ok) begin
          lwr.held    = 1'b0;
          lwr.rdone   = 1'b0;
          lwr.hclient = '0;
          lwr.hseq    = '0;
          r1_nxt      = '{kind: KIND_RETRY, status: ST_OK, client: fw_r.client,
                          seq: fw_r.seq};
          two_nxt     = prim_r && (ent_r.cnt != '0);
        end else begin
          r0_nxt.status = ST_ERR;
        end
        state_nxt = S_OUT0;
      end
      S_OUT0: begin
        if (out_tready) begin
          state_nxt = two_r ? S_OUT1 : S_IDLE;
        end
      end
      S_OUT1: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      prim_r  <= 1'b1;
      pv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pv_r    <= issue;
      if (cfg_wr_en) begin
        prim_r <= cfg_wr_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rel_r <= in_tuser[0];
      lk_r  <= in_tdata[7:0];
      cl_r  <= in_tdata[11:8];
      sq_r  <= in_tdata[43:12];
    end
    if (state_r == S_LOOK) begin
      ent_r <= lrd;
      len_r <= (rel_r == REQ_RELEASE) ? CNT_W'(lrd.cnt != '0) : lrd.cnt;
    end
    pi_r    <= rdi_r[CL_AW-1:0];
    rdi_r   <= rdi_nxt;
    w_r     <= w_nxt;
    found_r <= found_nxt;
    fw_r    <= fw_nxt;
    r0_r    <= r0_nxt;
    r1_r    <= r1_nxt;
    two_r   <= two_nxt;
  end

  res_t cur;
  assign cur        = (state_r == S_OUT1) ? r1_r : r0_r;
  assign out_tvalid = (state_r == S_OUT0) || (state_r == S_OUT1);
  assign out_tuser  = cur.kind;
  assign out_tlast  = (state_r == S_OUT1) || !two_r;
  assign out_tdata  = {2'b00, cur.seq, cur.client, lk_r, cur.status};

endmodule

FILE: design/ltr_checker.sv
`include "lock_table_with_revoke_retry_core_defines.svh"

module ltr_checker
  import ltr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  `LTR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  `LTR_ASSERT_NOW(a_no_overlap, in_tvalid && in_tready, !out_tvalid, "request taken while a result is pending")
  `LTR_ASSERT_NEXT(a_second_follows, out_tvalid && out_tready && !out_tlast, out_tvalid, "second result did not follow")
  `LTR_ASSERT_NOW(a_msg_last, out_tvalid && out_tuser != KIND_REPLY, out_tlast, "message not last of its request")

endmodule

bind lock_table_with_revoke_retry_core ltr_checker u_ltr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
